// ===== rtl/core/tobc_pkg.sv =====
// Package for the text output blank compressor: sizes, codes, byte constants,
// state and handshake types, and the alphanumeric test.
// No dependencies.
package tobc_pkg;

	localparam int TABLE_PAIRS = 40;
	localparam int TAB_STOP    = 8;   // power of two: divide and modulo reduce to shift and mask
	localparam int TBL_AW      = (TABLE_PAIRS > 1) ? $clog2(TABLE_PAIRS) : 1;
	localparam int CNT_W       = $clog2(TABLE_PAIRS + 1);
	localparam int CHAR_W      = 7;
	localparam int ENTRY_W     = 2 * CHAR_W;
	localparam int COUNT_W     = 12;
	localparam int CFG_W       = 15;
	localparam int CFG_IDX_W   = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] OP_EMIT  = 2'd0;
	localparam logic [1:0] OP_PAIR  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HARD_TABS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_PAGE  = 2'd2;

	localparam logic [7:0] BYTE_BS    = 8'd8;
	localparam logic [7:0] BYTE_TAB   = 8'd9;
	localparam logic [7:0] BYTE_SPACE = 8'd32;
	localparam logic [7:0] BYTE_UNDER = 8'd95;

	localparam logic [CHAR_W-1:0] CHR_SPACE   = 7'd32;
	localparam logic [CHAR_W-1:0] CHR_NEWLINE = 7'd10;

	localparam int SLOT_TAB   = 0;
	localparam int SLOT_SPACE = 1;
	localparam int SLOT_UNDER = 2;
	localparam int SLOT_BS    = 3;
	localparam int SLOT_CHAR  = 4;
	localparam int N_SLOTS    = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [CHAR_W-1:0] ch;
		logic [CNT_W-1:0]  len;
	} lkp_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [CHAR_W-1:0] ch;
	} lkp_rsp_t;

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return (c >= 7'd65 && c <= 7'd90) || (c >= 7'd97 && c <= 7'd122) ||
		       (c >= 7'd48 && c <= 7'd57);
	endfunction

endpackage

// ===== rtl/core/tobc_ram.sv =====
// Generic single-port RAM, one read or write per cycle, registered read data.
// No dependencies.
module tobc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                            wdata,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/core/tobc_lookup.sv =====
// Translation scan: walks the pair RAM one entry per cycle, one shared compare,
// first match wins. Depends on tobc_pkg.
module tobc_lookup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tobc_pkg::lkp_req_t                  req,
	output tobc_pkg::lkp_rsp_t                  rsp,
	output logic [tobc_pkg::TBL_AW-1:0]         ram_addr,
	input  logic [tobc_pkg::ENTRY_W-1:0]        ram_rdata
);
	import tobc_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  len_q;
	logic [CHAR_W-1:0] ch_q;
	logic              iss_s1;
	logic              last_s1;
	logic              issue;
	logic              hit;
	logic              done;

	assign ram_addr = rd_idx_q[TBL_AW-1:0];
	assign issue    = busy_q && (rd_idx_q < len_q);
	assign hit      = iss_s1 && (ram_rdata[ENTRY_W-1:CHAR_W] == ch_q);
	assign done     = busy_q && ((len_q == '0) || hit || (iss_s1 && last_s1));

	assign rsp.busy = busy_q;
	assign rsp.done = done;
	assign rsp.ch   = hit ? ram_rdata[CHAR_W-1:0] : ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_idx_q <= '0;
			iss_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else if (req.start) begin
			busy_q   <= 1'b1;
			rd_idx_q <= '0;
			iss_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else if (done) begin
			busy_q <= 1'b0;
			iss_s1 <= 1'b0;
		end else begin
			iss_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
				last_s1  <= (rd_idx_q == len_q - CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ch_q  <= req.ch;
			len_q <= req.len;
		end
	end

endmodule

// ===== rtl/core/text_output_blank_compressor_core.sv =====
// Top level of the text output blank compressor: sequencer, counters, pair RAM
// and output register. Depends on tobc_pkg, tobc_ram, tobc_lookup.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_ready     op, char_code, page_number, pair_index,
//                                              pair_from, pair_to
//  out      source     out_valid / out_ready   out_byte, repeat_count, last
//  cfg      sink       cfg_we                  cfg_index, cfg_data
//
// Pair write, clear and unknown ops are taken without leaving the idle state.
// A character is translated in the scan state (one pair compare per cycle through the pair
// RAM port) and planned in the plan state, then its 0 to 5 results go out one at a time;
// a result waits while the output register holds an untaken transfer.
// The pair RAM is not cleared at reset; only table_length, the counters and control reset.
// The next item is taken while the final result still waits in the output register.
module text_output_blank_compressor_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tobc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tobc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       op,
	input  logic [7:0]                       char_code,
	input  logic signed [15:0]               page_number,
	input  logic [5:0]                       pair_index,
	input  logic [6:0]                       pair_from,
	input  logic [6:0]                       pair_to,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte,
	output logic [tobc_pkg::COUNT_W-1:0]     repeat_count,
	output logic                             last
);
	import tobc_pkg::*;

	state_t state_q, state_d;

	logic               hte_q;
	logic [CFG_W-1:0]   first_q;
	logic [CFG_W-1:0]   lastpg_q;
	logic [CNT_W-1:0]   tbl_len_q;
	logic [COUNT_W-1:0] col_q;
	logic [COUNT_W-1:0] pend_q;

	logic               ul_q;
	logic signed [15:0] page_q;
	logic [CHAR_W-1:0]  ch_q;

	logic [N_SLOTS-1:0] slot_mask_q;
	logic [COUNT_W-1:0] tab_cnt_q;
	logic [COUNT_W-1:0] sp_cnt_q;

	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic               out_last_q;

	logic               acc_in;
	logic               pair_ok;
	logic               ram_we;
	logic [TBL_AW-1:0]  ram_addr;
	logic [TBL_AW-1:0]  lkp_addr;
	logic [ENTRY_W-1:0] ram_rdata;
	lkp_req_t           lkp_req;
	lkp_rsp_t           lkp_rsp;

	// planning
	logic               supp;
	logic               is_sp;
	logic               is_nl;
	logic               flush;
	logic [COUNT_W:0]   endc;
	logic [COUNT_W:0]   tabs;
	logic [COUNT_W:0]   rem;
	logic               tab_en;
	logic [COUNT_W-1:0] sp_cnt;
	logic [COUNT_W-1:0] base;
	logic [COUNT_W:0]   inc;
	logic [N_SLOTS-1:0] plan_mask;

	// emit
	logic               out_free;
	logic               load;
	logic [N_SLOTS-1:0] sel;
	logic [N_SLOTS-1:0] rem_mask;
	logic [7:0]         sel_byte;
	logic [COUNT_W-1:0] sel_cnt;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;
	assign pair_ok  = ({1'b0, pair_index} < 7'(TABLE_PAIRS));
	assign ram_we   = acc_in && (op == OP_PAIR) && pair_ok;
	assign ram_addr = (state_q == ST_SCAN) ? lkp_addr : pair_index[TBL_AW-1:0];

	assign lkp_req.start = acc_in && (op == OP_EMIT);
	assign lkp_req.ch    = char_code[CHAR_W-1:0];
	assign lkp_req.len   = tbl_len_q;

	tobc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_PAIRS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({pair_from, pair_to}),
		.rdata(ram_rdata)
	);

	tobc_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (lkp_req),
		.rsp      (lkp_rsp),
		.ram_addr (lkp_addr),
		.ram_rdata(ram_rdata)
	);

	always_comb begin
		supp   = (page_q < $signed({1'b0, first_q})) ||
		         ((lastpg_q != '0) && (page_q > $signed({1'b0, lastpg_q})));
		is_sp  = (ch_q == CHR_SPACE);
		is_nl  = (ch_q == CHR_NEWLINE);
		flush  = !is_sp && !is_nl && (pend_q != '0);
		endc   = {1'b0, col_q} + {1'b0, pend_q};
		tabs   = (COUNT_W+1)'(endc / TAB_STOP) - (COUNT_W+1)'({1'b0, col_q} / TAB_STOP);
		rem    = (COUNT_W+1)'(endc % TAB_STOP);
		tab_en = flush && hte_q && (pend_q > COUNT_W'(1)) && (tabs != '0);
		sp_cnt = tab_en ? rem[COUNT_W-1:0] : pend_q;
		if (!flush) begin
			base = col_q;
		end else if (endc[COUNT_W]) begin
			base = COUNT_MAX;
		end else begin
			base = endc[COUNT_W-1:0];
		end
		inc = {1'b0, base} + (COUNT_W+1)'(1);
		plan_mask             = '0;
		plan_mask[SLOT_TAB]   = tab_en;
		plan_mask[SLOT_SPACE] = flush && (sp_cnt != '0);
		plan_mask[SLOT_UNDER] = ul_q && is_alnum(ch_q);
		plan_mask[SLOT_BS]    = ul_q && is_alnum(ch_q);
		plan_mask[SLOT_CHAR]  = !is_sp;
	end

	always_comb begin
		sel      = slot_mask_q & (~slot_mask_q + N_SLOTS'(1));
		rem_mask = slot_mask_q & ~sel;
		sel_cnt  = COUNT_W'(1);
		if (sel[SLOT_TAB]) begin
			sel_byte = BYTE_TAB;
			sel_cnt  = tab_cnt_q;
		end else if (sel[SLOT_SPACE]) begin
			sel_byte = BYTE_SPACE;
			sel_cnt  = sp_cnt_q;
		end else if (sel[SLOT_UNDER]) begin
			sel_byte = BYTE_UNDER;
		end else if (sel[SLOT_BS]) begin
			sel_byte = BYTE_BS;
		end else begin
			sel_byte = {1'b0, ch_q};
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (lkp_req.start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (lkp_rsp.done) begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				state_d = supp ? ST_IDLE : (is_sp ? ST_IDLE : ST_EMIT);
			end
			ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (rem_mask == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hte_q    <= 1'b0;
			first_q  <= '0;
			lastpg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HARD_TABS:  hte_q    <= cfg_data[0];
				CFG_FIRST_PAGE: first_q  <= cfg_data;
				CFG_LAST_PAGE:  lastpg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_len_q   <= '0;
			col_q       <= '0;
			pend_q      <= '0;
			slot_mask_q <= '0;
		end else begin
			if (ram_we) begin
				tbl_len_q <= CNT_W'({1'b0, pair_index} + 7'd1);
			end else if (acc_in && (op == OP_CLEAR)) begin
				tbl_len_q <= '0;
			end
			if (state_q == ST_PLAN) begin
				slot_mask_q <= supp ? '0 : plan_mask;
				if (!supp) begin
					if (is_sp) begin
						if (pend_q != COUNT_MAX) begin
							pend_q <= pend_q + COUNT_W'(1);
						end
					end else if (is_nl) begin
						col_q  <= '0;
						pend_q <= '0;
					end else begin
						col_q  <= inc[COUNT_W] ? COUNT_MAX : inc[COUNT_W-1:0];
						pend_q <= '0;
					end
				end
			end else if (load) begin
				slot_mask_q <= rem_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			ul_q   <= char_code[7];
			page_q <= page_number;
		end
		if ((state_q == ST_SCAN) && lkp_rsp.done) begin
			ch_q <= lkp_rsp.ch;
		end
		if (state_q == ST_PLAN) begin
			tab_cnt_q <= tabs[COUNT_W-1:0];
			sp_cnt_q  <= sp_cnt;
		end
		if (load) begin
			out_byte_q <= sel_byte;
			out_cnt_q  <= sel_cnt;
			out_last_q <= (rem_mask == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign repeat_count = out_cnt_q;
	assign last         = out_last_q;

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		lkp_rsp.done |-> (state_q == ST_SCAN))
		else $error("lookup finished outside the scan state");

	a_idle_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !lkp_rsp.busy)
		else $error("input ready while the lookup is still running");

	a_emit_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (slot_mask_q != '0))
		else $error("emit state with no result left to send");

	a_newline_resets: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PLAN) && !supp && is_nl) |=> ((col_q == '0) && (pend_q == '0)))
		else $error("newline did not clear column and pending blanks");

endmodule
